[rtl/run_merge_sorter_macros.svh]
// Assertion macros for the run merge sorter.
// Used by the top level; expects clk and rst in the enclosing scope.
`ifndef RUN_MERGE_SORTER_MACROS_SVH
`define RUN_MERGE_SORTER_MACROS_SVH

// Checked property, disabled while reset is high.
`define RMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also covers reset cycles.
`define RMS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rms_pkg.sv]
// Shared constants and types for the run merge sorter.
// No dependencies.
`timescale 1ns / 1ps

package rms_pkg;

  localparam int RUN_LENGTH_DEF = 32;
  localparam int MAX_ITEMS_DEF  = 64;
  localparam int WORD_W         = 32;
  localparam int TALLY_W        = 12;
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TALLY_W-1:0] tally_t;

  // Tally controls from the sequencer.
  typedef struct packed {
    logic clear;
    logic inc_cmp;
    logic inc_move;
  } tally_ctl_t;

endpackage

[rtl/rms_cmp.sv]
// Shared signed comparator of the sort engine.
// Depends on rms_pkg.
`timescale 1ns / 1ps

module rms_cmp (
  input  rms_pkg::word_t a,
  input  rms_pkg::word_t b,
  output logic           gt
);
  import rms_pkg::*;

  // two's complement greater-than
  assign gt = $signed(a) > $signed(b);

endmodule

[rtl/rms_tally.sv]
// Saturating compare and move counters.
// Depends on rms_pkg.
`timescale 1ns / 1ps

module rms_tally (
  input  logic                clk,
  input  logic                rst,
  input  rms_pkg::tally_ctl_t ctl,
  output rms_pkg::tally_t     compare_count,
  output rms_pkg::tally_t     move_count
);
  import rms_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      compare_count <= '0;
      move_count    <= '0;
    end else begin
      if (ctl.inc_cmp && compare_count != TALLY_MAX) begin
        compare_count <= compare_count + TALLY_W'(1);
      end
      if (ctl.inc_move && move_count != TALLY_MAX) begin
        move_count <= move_count + TALLY_W'(1);
      end
    end
  end

endmodule

[rtl/run_merge_sorter.sv]
// Run merge sorter top level: load, sort sequencer, element memories, emit.
// Depends on rms_pkg, rms_cmp, rms_tally and run_merge_sorter_macros.svh.
`timescale 1ns / 1ps
`include "run_merge_sorter_macros.svh"

// Usage
//   Input channel valid/ready carries value and last. One beat per cycle is
//   taken while loading. The beat with last set, or the MAX_ITEMS-th beat,
//   closes the set and ready drops until the whole sorted set has left.
//   Output channel result_valid/result_ready carries sorted_value, final_res
//   and the two tallies; final_res marks the last beat of the set.
// Sort and emit
//   Sort: each run is insertion-sorted in place, then runs are merged in
//   passes of doubling width, each merge a copy into scratch, a prime of
//   the scratch reads, then the merge itself. All compares go through one
//   comparator, and the insertion sort and the copy share the single read
//   port of the element memory.
//   Emit: each beat is a memory read, then the output held until taken.
// Stall
//   A stalled receiver holds the current result beat; nothing else moves.
// Reset
//   rst clears the sequencer, load count and tallies; memories keep contents
//   and are always written before they are read.
module run_merge_sorter #(
  parameter int RUN_LENGTH = rms_pkg::RUN_LENGTH_DEF,
  parameter int MAX_ITEMS  = rms_pkg::MAX_ITEMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    ready,
  input  logic signed [31:0]      value,
  input  logic                    last,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic signed [31:0]      sorted_value,
  output logic                    final_res,
  output rms_pkg::tally_t         compare_count,
  output rms_pkg::tally_t         move_count
);
  import rms_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW = $clog2(MAX_ITEMS + 1);
  // loop indices can run past the set by up to two merge widths
  localparam int CW = $clog2(3 * MAX_ITEMS + RUN_LENGTH + 1);

  typedef enum logic [12:0] {
    ST_LOAD     = 13'b0000000000001,
    ST_RUN      = 13'b0000000000010,
    ST_KEY_RD   = 13'b0000000000100,
    ST_KEY_LD   = 13'b0000000001000,
    ST_INS_CMP  = 13'b0000000010000,
    ST_PLACE    = 13'b0000000100000,
    ST_MSTART   = 13'b0000001000000,
    ST_MPASS    = 13'b0000010000000,
    ST_MCPY     = 13'b0000100000000,
    ST_MPRIME   = 13'b0001000000000,
    ST_MERGE    = 13'b0010000000000,
    ST_EMIT_RD  = 13'b0100000000000,
    ST_EMIT_OUT = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // load / emit counters
  logic [NW-1:0] cnt, cnt_next;
  logic [NW-1:0] n_q, n_next;
  logic [NW-1:0] e, e_next;
  logic          fin, fin_next;

  // sort loop registers
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] a, a_next;
  logic [CW-1:0] b, b_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] ck, ck_next;
  logic [AW-1:0] cw, cw_next;
  logic          cp_vld, cp_vld_next;
  logic [AW-1:0] pos, pos_next;
  word_t         key, key_next;

  // element memory ports
  word_t         st_mem [MAX_ITEMS];
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  word_t         st_wdata, st_rd;

  // scratch memory ports
  word_t         sc_mem [MAX_ITEMS];
  logic          sc_we, sc_re;
  logic [AW-1:0] sc_waddr, sc_ra_a, sc_ra_b;
  word_t         sc_wdata, sc_rd_a, sc_rd_b;

  // shared compare
  word_t         cmp_a, cmp_b;
  logic          gt;

  tally_ctl_t    tctl;

  // loop bounds
  logic [CW-1:0] n_ext, n_m1, lo_p_rl, ins_hi, w2, lo_p_2w, mg_mid, mg_hi;
  logic          a_ok, b_ok;

  assign n_ext   = CW'(n_q);
  assign n_m1    = n_ext - CW'(1);
  assign lo_p_rl = lo + CW'(RUN_LENGTH);
  assign ins_hi  = ((lo_p_rl - CW'(1)) > n_m1) ? n_m1 : (lo_p_rl - CW'(1));
  assign w2      = w << 1;
  assign lo_p_2w = lo + w2;
  assign mg_mid  = lo + w - CW'(1);
  assign mg_hi   = ((lo_p_2w - CW'(1)) > n_m1) ? n_m1 : (lo_p_2w - CW'(1));
  assign a_ok    = a <= mid;
  assign b_ok    = b <= hi;

  rms_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (gt)
  );

  rms_tally u_tally (
    .clk           (clk),
    .rst           (rst),
    .ctl           (tctl),
    .compare_count (compare_count),
    .move_count    (move_count)
  );

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    n_next      = n_q;
    e_next      = e;
    fin_next    = fin;
    lo_next     = lo;
    hi_next     = hi;
    i_next      = i;
    j_next      = j;
    w_next      = w;
    mid_next    = mid;
    a_next      = a;
    b_next      = b;
    k_next      = k;
    ck_next     = ck;
    cw_next     = cw;
    cp_vld_next = cp_vld;
    pos_next    = pos;
    key_next    = key;
    st_we       = 1'b0;
    st_waddr    = '0;
    st_wdata    = st_rd;
    st_re       = 1'b0;
    st_raddr    = '0;
    sc_we       = 1'b0;
    sc_waddr    = cw;
    sc_wdata    = st_rd;
    sc_re       = 1'b0;
    sc_ra_a     = a[AW-1:0];
    sc_ra_b     = b[AW-1:0];
    cmp_a       = st_rd;
    cmp_b       = key;
    tctl        = '0;
    ready        = 1'b0;
    result_valid = 1'b0;

    unique case (state)
      ST_LOAD: begin
        ready = 1'b1;
        if (valid) begin
          st_we    = 1'b1;
          st_waddr = cnt[AW-1:0];
          st_wdata = word_t'(value);
          cnt_next = cnt + NW'(1);
          if (last || (cnt + NW'(1)) == NW'(MAX_ITEMS)) begin
            n_next     = cnt + NW'(1);
            cnt_next   = '0;
            lo_next    = '0;
            state_next = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        if (lo >= n_ext) begin
          w_next     = CW'(RUN_LENGTH);
          state_next = ST_MSTART;
        end else begin
          hi_next = ins_hi;
          i_next  = lo + CW'(1);
          if ((lo + CW'(1)) > ins_hi) begin
            lo_next = lo_p_rl;          // one-element run
          end else begin
            state_next = ST_KEY_RD;
          end
        end
      end

      ST_KEY_RD: begin
        st_re      = 1'b1;
        st_raddr   = i[AW-1:0];
        state_next = ST_KEY_LD;
      end

      ST_KEY_LD: begin
        key_next      = st_rd;
        tctl.inc_move = 1'b1;
        j_next        = i - CW'(1);
        st_re         = 1'b1;
        st_raddr      = AW'(i - CW'(1));
        state_next    = ST_INS_CMP;
      end

      ST_INS_CMP: begin
        tctl.inc_cmp = 1'b1;
        if (gt) begin
          st_we         = 1'b1;
          st_waddr      = AW'(j + CW'(1));
          st_wdata      = st_rd;
          tctl.inc_move = 1'b1;
          if (j == lo) begin
            pos_next   = lo[AW-1:0];
            state_next = ST_PLACE;
          end else begin
            j_next   = j - CW'(1);
            st_re    = 1'b1;
            st_raddr = AW'(j - CW'(1));
          end
        end else begin
          pos_next   = AW'(j + CW'(1));
          state_next = ST_PLACE;
        end
      end

      ST_PLACE: begin
        st_we         = 1'b1;
        st_waddr      = pos;
        st_wdata      = key;
        tctl.inc_move = 1'b1;
        i_next        = i + CW'(1);
        if ((i + CW'(1)) > hi) begin
          lo_next    = lo_p_rl;
          state_next = ST_RUN;
        end else begin
          state_next = ST_KEY_RD;
        end
      end

      ST_MSTART: begin
        if (w >= n_ext) begin
          e_next     = '0;
          state_next = ST_EMIT_RD;
        end else begin
          lo_next    = '0;
          state_next = ST_MPASS;
        end
      end

      ST_MPASS: begin
        if (lo >= n_ext) begin
          w_next     = w2;
          state_next = ST_MSTART;
        end else if (mg_mid < mg_hi) begin
          mid_next    = mg_mid;
          hi_next     = mg_hi;
          a_next      = lo;
          b_next      = mg_mid + CW'(1);
          k_next      = lo;
          ck_next     = lo;
          cp_vld_next = 1'b0;
          state_next  = ST_MCPY;
        end else begin
          lo_next = lo_p_2w;            // lone tail, nothing to merge
        end
      end

      ST_MCPY: begin
        // read element ck while the previous word lands in scratch
        if (ck <= hi) begin
          st_re    = 1'b1;
          st_raddr = ck[AW-1:0];
          ck_next  = ck + CW'(1);
        end
        cp_vld_next = ck <= hi;
        cw_next     = ck[AW-1:0];
        if (cp_vld) begin
          sc_we    = 1'b1;
          sc_waddr = cw;
          sc_wdata = st_rd;
        end
        if (!(ck <= hi) && !cp_vld) begin
          state_next = ST_MPRIME;
        end
      end

      ST_MPRIME: begin
        sc_re      = 1'b1;
        state_next = ST_MERGE;
      end

      ST_MERGE: begin
        cmp_a = sc_rd_a;
        cmp_b = sc_rd_b;
        priority if (a_ok && b_ok) begin
          tctl.inc_cmp  = 1'b1;
          tctl.inc_move = 1'b1;
          st_we         = 1'b1;
          st_waddr      = k[AW-1:0];
          if (gt) begin
            st_wdata = sc_rd_b;
            b_next   = b + CW'(1);
          end else begin
            st_wdata = sc_rd_a;         // ties go left
            a_next   = a + CW'(1);
          end
          k_next = k + CW'(1);
        end else if (a_ok) begin
          tctl.inc_move = 1'b1;
          st_we         = 1'b1;
          st_waddr      = k[AW-1:0];
          st_wdata      = sc_rd_a;
          a_next        = a + CW'(1);
          k_next        = k + CW'(1);
        end else if (b_ok) begin
          tctl.inc_move = 1'b1;
          st_we         = 1'b1;
          st_waddr      = k[AW-1:0];
          st_wdata      = sc_rd_b;
          b_next        = b + CW'(1);
          k_next        = k + CW'(1);
        end else begin
          lo_next    = lo_p_2w;
          state_next = ST_MPASS;
        end
        // prefetch heads for the next step
        sc_re   = 1'b1;
        sc_ra_a = a_next[AW-1:0];
        sc_ra_b = b_next[AW-1:0];
      end

      ST_EMIT_RD: begin
        st_re      = 1'b1;
        st_raddr   = e[AW-1:0];
        fin_next   = e == (n_q - NW'(1));
        state_next = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        result_valid = 1'b1;
        if (result_ready) begin
          e_next = e + NW'(1);
          if (fin) begin
            tctl.clear = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      cnt    <= '0;
      cp_vld <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      cp_vld <= cp_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    n_q <= n_next;
    e   <= e_next;
    fin <= fin_next;
    lo  <= lo_next;
    hi  <= hi_next;
    i   <= i_next;
    j   <= j_next;
    w   <= w_next;
    mid <= mid_next;
    a   <= a_next;
    b   <= b_next;
    k   <= k_next;
    ck  <= ck_next;
    cw  <= cw_next;
    pos <= pos_next;
    key <= key_next;
  end

  // element memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rd <= st_mem[st_raddr];
    end
  end

  // scratch memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    if (sc_re) begin
      sc_rd_a <= sc_mem[sc_ra_a];
      sc_rd_b <= sc_mem[sc_ra_b];
    end
  end

  assign sorted_value = $signed(st_rd);
  assign final_res    = fin;

  `RMS_ASSERT(a_no_overlap, !(ready && result_valid), "load and emit overlap")
  `RMS_ASSERT(a_tally_hold, (result_valid && !final_res) |=> ($stable(compare_count) && $stable(move_count)), "tally moved during emit")
  `RMS_ASSERT(a_ins_range, (state == ST_INS_CMP) |-> ((j >= lo) && (j < hi)), "insertion index out of run")
  `RMS_ASSERT(a_merge_range, ((state == ST_MERGE) && st_we) |-> (k <= hi), "merge wrote past its span")
  `RMS_ASSERT_RST(a_reset_load, rst |=> (ready && !result_valid), "not loading after reset")

endmodule
